// ===== design/acrs_pkg.sv =====
// Package for the atom center rank sorter: widths, types and register codes.
// No dependencies.
package acrs_pkg;

  localparam int AtomicBits = 7;
  localparam int IndexBits  = 6;

  typedef enum logic [1:0] {
    REG_CENTER_X = 2'd0,
    REG_CENTER_Y = 2'd1,
    REG_CENTER_Z = 2'd2
  } cfg_reg_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_WAIT,
    ST_EMIT,
    ST_DONE
  } back_state_e;

endpackage

// ===== design/acrs_if.sv =====
// Valid/ready channel interfaces for the atom center rank sorter.
// Depends on nothing but the parameters given at instantiation.
interface acrs_in_if #(parameter int CoordBits = 24);
  logic                        valid;
  logic                        ready;
  logic [6:0]                  atomic_number;
  logic signed [CoordBits-1:0] pos_x;
  logic signed [CoordBits-1:0] pos_y;
  logic signed [CoordBits-1:0] pos_z;
  logic                        last_atom;
  modport source (output valid, atomic_number, pos_x, pos_y, pos_z, last_atom,
                  input ready);
  modport sink (input valid, atomic_number, pos_x, pos_y, pos_z, last_atom,
                output ready);
endinterface

interface acrs_out_if;
  logic       valid;
  logic       ready;
  logic [5:0] atom_index;
  logic       last_rank;
  logic       overflow;
  modport source (output valid, atom_index, last_rank, overflow, input ready);
  modport sink (input valid, atom_index, last_rank, overflow, output ready);
endinterface

interface acrs_cfg_if #(parameter int CoordBits = 24);
  logic                 valid;
  logic                 ready;
  logic [1:0]           index;
  logic [CoordBits-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ===== design/acrs_front.sv =====
// Front part: takes atom transfers, forms squared distance with one shared
// multiplier, and pushes key records into the queue.
// Depends on acrs_pkg.
module acrs_front
  import acrs_pkg::*;
#(
  parameter int CoordBits = 24,
  parameter int DistBits  = 2 * CoordBits + 2
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [AtomicBits-1:0]       atomic_i,
  input  logic signed [CoordBits-1:0] pos_x_i,
  input  logic signed [CoordBits-1:0] pos_y_i,
  input  logic signed [CoordBits-1:0] pos_z_i,
  input  logic                        last_i,
  input  logic signed [CoordBits-1:0] cx_i,
  input  logic signed [CoordBits-1:0] cy_i,
  input  logic signed [CoordBits-1:0] cz_i,
  output logic                        q_valid_o,
  input  logic                        q_ready_i,
  output logic [AtomicBits-1:0]       q_atomic_o,
  output logic [DistBits-1:0]         q_dist_o,
  output logic                        q_last_o
);
  localparam int DBits = CoordBits + 1;

  logic                    busy_q, busy_d;
  logic [1:0]              step_q, step_d;
  logic [DBits-1:0]        mag_q [3];
  logic [DistBits-1:0]     acc_q, acc_d;
  logic [AtomicBits-1:0]   atomic_q;
  logic                    last_q;
  logic                    out_v_q, out_v_d;
  logic signed [DBits-1:0] dx, dy, dz;
  logic [2*DBits-1:0]      prod;
  logic                    take;

  assign dx = DBits'(pos_x_i) - DBits'(cx_i);
  assign dy = DBits'(pos_y_i) - DBits'(cy_i);
  assign dz = DBits'(pos_z_i) - DBits'(cz_i);
  assign in_ready_o = !busy_q && !out_v_q;
  assign take = in_valid_i && in_ready_o;
  assign prod = {{DBits{1'b0}}, mag_q[step_q]} * {{DBits{1'b0}}, mag_q[step_q]};

  always_comb begin
    busy_d  = busy_q;
    step_d  = step_q;
    acc_d   = acc_q;
    out_v_d = out_v_q;
    if (take) begin
      busy_d = 1'b1;
      step_d = 2'd0;
      acc_d  = '0;
    end else if (busy_q) begin
      acc_d = acc_q + DistBits'(prod);
      if (step_q == 2'd2) begin
        busy_d  = 1'b0;
        out_v_d = 1'b1;
      end else begin
        step_d = step_q + 2'd1;
      end
    end
    if (out_v_q && q_ready_i) out_v_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q  <= 1'b0;
      out_v_q <= 1'b0;
      step_q  <= '0;
    end else begin
      busy_q  <= busy_d;
      out_v_q <= out_v_d;
      step_q  <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
    if (take) begin
      mag_q[0] <= dx[DBits-1] ? DBits'(-dx) : DBits'(dx);
      mag_q[1] <= dy[DBits-1] ? DBits'(-dy) : DBits'(dy);
      mag_q[2] <= dz[DBits-1] ? DBits'(-dz) : DBits'(dz);
      atomic_q <= atomic_i;
      last_q   <= last_i;
    end
  end

  assign q_valid_o  = out_v_q;
  assign q_atomic_o = atomic_q;
  assign q_dist_o   = acc_q;
  assign q_last_o   = last_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni) take |=> busy_q)
    else $error("front did not start on a transfer");
  assert property (@(posedge clk_i) disable iff (!rst_ni) busy_q |-> !in_ready_o)
    else $error("front ready while busy");
  assert property (@(posedge clk_i) disable iff (!rst_ni) busy_q |-> step_q != 2'd3)
    else $error("front step out of range");
endmodule

// ===== design/acrs_ram.sv =====
// Generic single-port-write, single-read RAM with registered read data.
// No dependencies.
module acrs_ram #(
  parameter int Width = 8,
  parameter int Depth = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];
  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[waddr_i] <= wdata_i;
    rdata_o <= mem_q[raddr_i];
  end
endmodule

// ===== design/acrs_back.sv =====
// Back part: stores key records, then for each rank scans the store for the
// smallest key above the previous one and emits its load index.
// Depends on acrs_pkg and acrs_ram.
module acrs_back
  import acrs_pkg::*;
#(
  parameter int MaxAtoms = 64,
  parameter int DistBits = 50
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  q_valid_i,
  output logic                  q_ready_o,
  input  logic [AtomicBits-1:0] q_atomic_i,
  input  logic [DistBits-1:0]   q_dist_i,
  input  logic                  q_last_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic [IndexBits-1:0]  out_index_o,
  output logic                  out_last_o,
  output logic                  out_ovf_o
);
  localparam int AW = $clog2(MaxAtoms);
  localparam int CW = $clog2(MaxAtoms + 1);
  localparam int KW = AtomicBits + DistBits;
  localparam int FW = KW + AW;

  back_state_e     st_q, st_d;
  logic [CW-1:0]   cnt_q, cnt_d;
  logic            ovf_q, ovf_d;
  logic [CW-1:0]   rank_q, rank_d;
  logic [CW-1:0]   scan_q, scan_d;
  logic            rv_q;
  logic [AW-1:0]   ridx_q;
  logic [FW-1:0]   prev_q, prev_d, best_q, best_d;
  logic            have_prev_q, have_prev_d, have_best_q, have_best_d;
  logic [KW-1:0]   rdata;
  logic [FW-1:0]   cand;
  logic            store, above, below;

  assign store = (st_q == ST_IDLE) && q_valid_i && (cnt_q < CW'(MaxAtoms));

  acrs_ram #(.Width(KW), .Depth(1 << AW)) u_keys (
    .clk_i  (clk_i),
    .we_i   (store),
    .waddr_i(cnt_q[AW-1:0]),
    .wdata_i({q_atomic_i, q_dist_i}),
    .raddr_i(scan_q[AW-1:0]),
    .rdata_o(rdata)
  );

  // Full key = {atomic, dist, index}; unique, so a strict compare is a total order.
  assign cand  = {rdata, ridx_q};
  assign above = !have_prev_q || (cand > prev_q);
  assign below = !have_best_q || (cand < best_q);

  assign q_ready_o   = (st_q == ST_IDLE);
  assign out_valid_o = (st_q == ST_EMIT);
  assign out_index_o = IndexBits'(best_q[AW-1:0]);
  assign out_last_o  = (rank_q + CW'(1) == cnt_q);
  assign out_ovf_o   = ovf_q;

  always_comb begin
    st_d = st_q; cnt_d = cnt_q; ovf_d = ovf_q; rank_d = rank_q; scan_d = scan_q;
    prev_d = prev_q; best_d = best_q; have_prev_d = have_prev_q;
    have_best_d = have_best_q;
    if (rv_q && above && below) begin
      best_d = cand;
      have_best_d = 1'b1;
    end
    unique case (st_q)
      ST_IDLE: begin
        if (q_valid_i) begin
          if (store) cnt_d = cnt_q + CW'(1);
          else ovf_d = 1'b1;
          if (q_last_i) begin
            if (cnt_d == '0) begin
              st_d = ST_IDLE;
              ovf_d = 1'b0;
            end else begin
              st_d = ST_SCAN;
              rank_d = '0; scan_d = '0;
              have_prev_d = 1'b0; have_best_d = 1'b0;
            end
          end
        end
      end
      ST_SCAN: begin
        scan_d = scan_q + CW'(1);
        if (scan_q + CW'(1) == cnt_q) st_d = ST_WAIT;
      end
      ST_WAIT: st_d = ST_EMIT;
      ST_EMIT: begin
        if (out_ready_i) begin
          prev_d = best_q; have_prev_d = 1'b1; have_best_d = 1'b0;
          scan_d = '0; rank_d = rank_q + CW'(1);
          if (out_last_o) begin
            st_d = ST_IDLE; cnt_d = '0; ovf_d = 1'b0;
          end else begin
            st_d = ST_SCAN;
          end
        end
      end
      default: st_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= ST_IDLE; cnt_q <= '0; ovf_q <= 1'b0; rank_q <= '0; scan_q <= '0;
      rv_q <= 1'b0; have_prev_q <= 1'b0; have_best_q <= 1'b0;
    end else begin
      st_q <= st_d; cnt_q <= cnt_d; ovf_q <= ovf_d; rank_q <= rank_d;
      scan_q <= scan_d; rv_q <= (st_q == ST_SCAN);
      have_prev_q <= have_prev_d; have_best_q <= have_best_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ridx_q <= scan_q[AW-1:0];
    prev_q <= prev_d;
    best_q <= best_d;
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni) cnt_q <= CW'(MaxAtoms))
    else $error("atom count beyond store");
  assert property (@(posedge clk_i) disable iff (!rst_ni) out_valid_o |-> have_best_q)
    else $error("emit without a selected atom");
  assert property (@(posedge clk_i) disable iff (!rst_ni) out_valid_o |-> rank_q < cnt_q)
    else $error("rank beyond atom count");
endmodule

// ===== design/atom_center_rank_sorter.sv =====
// Atom center rank sorter. The front squares three axis offsets with one shared
// squarer and sums them, and takes no new atom until its key has passed to the
// back part. After the last atom, the back part scans the stored keys once per
// rank and emits the ranks in turn, smallest key first.
// Reset (async, active low) clears count, overflow flag and centers; the key
// store holds no reset value and is only read where written in this run.
module atom_center_rank_sorter
  import acrs_pkg::*;
#(
  parameter int MAX_ATOMS  = 64,
  parameter int COORD_BITS = 24
) (
  input logic         clk_i,
  input logic         rst_ni,
  acrs_cfg_if.sink    cfg,
  acrs_in_if.sink     in_ch,
  acrs_out_if.source  out_ch
);
  localparam int DistBits = 2 * COORD_BITS + 2;

  // Center registers; cfg is always ready, so every write is taken when presented.
  logic signed [COORD_BITS-1:0] cx_q, cy_q, cz_q;
  assign cfg.ready = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cx_q <= '0; cy_q <= '0; cz_q <= '0;
    end else if (cfg.valid) begin
      case (cfg.index)
        REG_CENTER_X: cx_q <= cfg.data;
        REG_CENTER_Y: cy_q <= cfg.data;
        REG_CENTER_Z: cz_q <= cfg.data;
        default: ;
      endcase
    end
  end

  logic                  q_valid, q_ready, q_last;
  logic [AtomicBits-1:0] q_atomic;
  logic [DistBits-1:0]   q_dist;

  // The front output register is the one-deep queue to the back part.
  acrs_front #(.CoordBits(COORD_BITS), .DistBits(DistBits)) u_front (
    .clk_i, .rst_ni,
    .in_valid_i(in_ch.valid), .in_ready_o(in_ch.ready),
    .atomic_i(in_ch.atomic_number), .pos_x_i(in_ch.pos_x), .pos_y_i(in_ch.pos_y),
    .pos_z_i(in_ch.pos_z), .last_i(in_ch.last_atom),
    .cx_i(cx_q), .cy_i(cy_q), .cz_i(cz_q),
    .q_valid_o(q_valid), .q_ready_i(q_ready), .q_atomic_o(q_atomic),
    .q_dist_o(q_dist), .q_last_o(q_last)
  );

  acrs_back #(.MaxAtoms(MAX_ATOMS), .DistBits(DistBits)) u_back (
    .clk_i, .rst_ni,
    .q_valid_i(q_valid), .q_ready_o(q_ready), .q_atomic_i(q_atomic),
    .q_dist_i(q_dist), .q_last_i(q_last),
    .out_valid_o(out_ch.valid), .out_ready_i(out_ch.ready),
    .out_index_o(out_ch.atom_index), .out_last_o(out_ch.last_rank),
    .out_ovf_o(out_ch.overflow)
  );
endmodule
